### hdl/plsu_pkg.sv
// Shared types and codes for the positional list store.
`default_nettype none

package plsu_pkg;

    // Request action codes
    localparam logic [2:0] ACT_ADD_FRONT = 3'd0;
    localparam logic [2:0] ACT_ADD_REAR  = 3'd1;
    localparam logic [2:0] ACT_DEL_FRONT = 3'd2;
    localparam logic [2:0] ACT_DEL_REAR  = 3'd3;
    localparam logic [2:0] ACT_INS_POS   = 3'd4;
    localparam logic [2:0] ACT_DEL_POS   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  position;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] removed_value;
        logic [6:0]  item_count;
    } out_item_t;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INS_RD  = 8'b0000_0010,
        S_INS_WR  = 8'b0000_0100,
        S_DEL_GET = 8'b0000_1000,
        S_DEL_CAP = 8'b0001_0000,
        S_DEL_RD  = 8'b0010_0000,
        S_DEL_WR  = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } seq_state_t;

endpackage

`default_nettype wire

### hdl/plsu_mem.sv
// Element memory: one write port, one read port with registered read data.
`default_nettype none

module plsu_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/plsu_seq.sv
// Request sequencer: decode, element count, and the shared index stepper that walks the memory.
`default_nettype none

module plsu_seq
    import plsu_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire in_item_t                    in_item,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output out_item_t                        res_item,
    output logic                             mem_we,
    output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
    output logic [ELEM_WIDTH-1:0]            mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
    input  wire logic [ELEM_WIDTH-1:0]       mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = ((CW > 7) ? CW : 7) + 1;

    seq_state_t            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic [AW-1:0]         tgt_reg, tgt_next;
    logic [1:0]            status_reg, status_next;
    logic [ELEM_WIDTH-1:0] removed_reg, removed_next;
    logic [ELEM_WIDTH-1:0] value_reg, value_next;

    // Shared index stepper
    logic          step_down;
    logic [AW:0]   step_sum;
    logic [AW-1:0] step_idx;

    // Decode
    logic [WW-1:0] cnt_ext, pos_ext;
    logic          is_full, is_empty;
    logic [AW-1:0] pos_m1, count_idx, count_m1;
    logic [1:0]    dec_status;
    logic          dec_ins, dec_del;
    logic [AW-1:0] dec_idx;

    assign step_down = (state_reg == S_INS_RD) || (state_reg == S_INS_WR);
    assign step_sum  = (AW+1)'(cur_reg) + (step_down ? {(AW+1){1'b1}} : (AW+1)'(1));
    assign step_idx  = step_sum[AW-1:0];

    assign cnt_ext   = WW'(count_reg);
    assign pos_ext   = WW'(in_item.position);
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign pos_m1    = AW'(pos_ext - WW'(1));
    assign count_idx = AW'(count_reg);
    assign count_m1  = AW'(cnt_ext - WW'(1));

    always_comb begin
        dec_status = ST_OK;
        dec_ins    = 1'b0;
        dec_del    = 1'b0;
        dec_idx    = '0;
        case (in_item.action)
            ACT_ADD_FRONT, ACT_ADD_REAR: begin
                if (is_full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_ins = 1'b1;
                    dec_idx = (in_item.action == ACT_ADD_FRONT) ? '0 : count_idx;
                end
            end
            ACT_DEL_FRONT, ACT_DEL_REAR: begin
                if (is_empty) begin
                    dec_status = ST_UNDERFLOW;
                end else begin
                    dec_del = 1'b1;
                    dec_idx = (in_item.action == ACT_DEL_FRONT) ? '0 : count_m1;
                end
            end
            ACT_INS_POS: begin
                if (pos_ext == '0 || pos_ext > cnt_ext + WW'(1)) begin
                    dec_status = ST_RANGE;
                end else if (is_full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_ins = 1'b1;
                    dec_idx = pos_m1;
                end
            end
            ACT_DEL_POS: begin
                if (pos_ext == '0 || pos_ext > cnt_ext) begin
                    dec_status = ST_RANGE;
                end else begin
                    dec_del = 1'b1;
                    dec_idx = pos_m1;
                end
            end
            default: begin
                dec_status = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        tgt_next     = tgt_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        value_next   = value_reg;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg;
        mem_wdata    = value_reg;
        mem_raddr    = cur_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    value_next   = ELEM_WIDTH'(in_item.value);
                    removed_next = '0;
                    status_next  = dec_status;
                    tgt_next     = dec_idx;
                    cur_next     = dec_ins ? count_idx : dec_idx;
                    if (dec_ins) begin
                        state_next = S_INS_RD;
                    end else if (dec_del) begin
                        state_next = S_DEL_GET;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_INS_RD: begin
                if (cur_reg == tgt_reg) begin
                    // gap has reached the target slot: drop the new value in
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_RESP;
                end else begin
                    mem_raddr  = step_idx;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                cur_next   = step_idx;
                state_next = S_INS_RD;
            end
            S_DEL_GET: begin
                state_next = S_DEL_CAP;
            end
            S_DEL_CAP: begin
                removed_next = mem_rdata;
                state_next   = S_DEL_RD;
            end
            S_DEL_RD: begin
                if (WW'(step_sum) == cnt_ext) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end else begin
                    mem_raddr  = step_idx;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                cur_next   = step_idx;
                state_next = S_DEL_RD;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        cur_reg     <= cur_next;
        tgt_reg     <= tgt_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        value_reg   <= value_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res_item  = '{status:        status_reg,
                         removed_value: 32'(removed_reg),
                         item_count:    7'(count_reg)};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_INS_RD || state_reg == S_INS_WR || state_reg == S_DEL_WR))
        else $error("memory write outside a shift step");

    a_write_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (WW'(mem_waddr) <= cnt_ext))
        else $error("memory write past the end of the list");

    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(count_reg)) |-> (state_reg == S_RESP))
        else $error("count changed without finishing a request");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item left sequencer idle");
`endif

endmodule

`default_nettype wire

### hdl/positional_list_store_unit.sv
// Top level of the positional list store: sequencer, element memory and result register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_item  (action, position, value)
//  m_      | out       | m_valid / m_ready  | m_item  (status, removed_value, item_count)
//
// Shifting: an add moves up to CAPACITY-1 elements one place toward the rear; a removal first
//   reads out the taken value and then moves the elements behind it one place toward the front.
//   Failed requests go straight to the result. Each shift step is a read then a write on the
//   single-port pair.
// Reset: aresetn synchronous, active low; the list comes up empty, memory is left as is.
// Stalls: s_ready is high only while the sequencer is idle; a result parks in the output
//   register, so the next item is taken while m_valid waits on m_ready.
`default_nettype none

module positional_list_store_unit
    import plsu_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    localparam int AW = $clog2(CAPACITY);

    logic                  res_valid;
    logic                  res_ready;
    out_item_t             res_item;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [ELEM_WIDTH-1:0] mem_rdata;

    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg, m_item_next;

    // Walk the list and keep the count
    plsu_seq #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Elements, front first
    plsu_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEM_WIDTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Take a new result whenever the output register is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_item_next = res_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the positional list store: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import plsu_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int RANDOM_ITEMS = 1800;

    // Action codes the block does not define; both must come back as out of range.
    localparam logic [2:0] ACT_UNDEF_6 = 3'd6;
    localparam logic [2:0] ACT_UNDEF_7 = 3'd7;

    // Traffic trend of one random segment: grow toward full, drain toward empty, or mix.
    typedef enum int {TREND_GROW, TREND_DRAIN, TREND_MIX} list_trend_t;

    // One row of the directed table; expected result is used only where has_exp is set.
    typedef struct packed {
        in_item_t  req;
        bit        has_exp;
        out_item_t exp;
    } directed_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Shadow copy of the list, front first, and its element count.
    logic [31:0] shadow_list [LIST_DEPTH];
    int          shadow_len = 0;

    out_item_t   pending_results [$];
    int          items_in = 0;
    int          mismatch_count = 0;

    directed_row_t directed_rows [0:23];

    positional_list_store_unit #(
        .CAPACITY   (LIST_DEPTH),
        .ELEM_WIDTH (32)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Run the request against the shadow list and return the result the block owes for it.
    function automatic out_item_t apply_request(input in_item_t rq);
        out_item_t res;
        int        slot;
        int        k;
        bit        adding;
        bit        taking;
        res    = '0;
        slot   = 0;
        adding = 1'b0;
        taking = 1'b0;
        case (rq.action)
            ACT_ADD_FRONT, ACT_ADD_REAR: begin
                if (shadow_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    adding = 1'b1;
                    slot = (rq.action == ACT_ADD_FRONT) ? 0 : shadow_len;
                end
            end
            ACT_DEL_FRONT, ACT_DEL_REAR: begin
                if (shadow_len == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    taking = 1'b1;
                    slot = (rq.action == ACT_DEL_FRONT) ? 0 : shadow_len - 1;
                end
            end
            ACT_INS_POS: begin
                // range test comes before the full test
                if (rq.position < 1 || rq.position > shadow_len + 1) begin
                    res.status = ST_RANGE;
                end else if (shadow_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    adding = 1'b1;
                    slot = rq.position - 1;
                end
            end
            ACT_DEL_POS: begin
                // an empty list reports out of range here, not underflow
                if (rq.position < 1 || rq.position > shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    taking = 1'b1;
                    slot = rq.position - 1;
                end
            end
            default: begin
                res.status = ST_RANGE;
            end
        endcase
        if (adding) begin
            // open a hole at slot by moving the tail one place toward the rear
            for (k = shadow_len; k > slot; k--) begin
                shadow_list[k] = shadow_list[k - 1];
            end
            shadow_list[slot] = rq.value;
            shadow_len++;
        end
        if (taking) begin
            // close the hole by moving the tail one place toward the front
            res.removed_value = shadow_list[slot];
            for (k = slot; k + 1 < shadow_len; k++) begin
                shadow_list[k] = shadow_list[k + 1];
            end
            shadow_len--;
        end
        res.item_count = shadow_len[6:0];
        return res;
    endfunction

    function automatic directed_row_t drow(input logic [2:0] act, input logic [6:0] pos,
                                           input logic [31:0] val, input bit has_exp,
                                           input logic [1:0] st, input logic [31:0] rem,
                                           input logic [6:0] cnt);
        directed_row_t r;
        r.req.action          = act;
        r.req.position        = pos;
        r.req.value           = val;
        r.has_exp             = has_exp;
        r.exp.status          = st;
        r.exp.removed_value   = rem;
        r.exp.item_count      = cnt;
        return r;
    endfunction

    // Stretch of the run in which neither side idles.
    function automatic bit quiet_stretch();
        return items_in >= 900 && items_in < 1200;
    endfunction

    // Build one random request, mostly well formed for the current length of the list.
    function automatic in_item_t next_random(input list_trend_t trend);
        in_item_t rq;
        int       add_pct;
        int       kind;
        bit       adding;
        rq.value = $urandom();
        if ($urandom_range(99) < 4) begin
            // noise: any action, any position the field can carry
            rq.action   = 3'($urandom_range(7));
            rq.position = 7'($urandom_range(127));
            return rq;
        end
        case (trend)
            TREND_GROW:  add_pct = 75;
            TREND_DRAIN: add_pct = 25;
            default:     add_pct = 50;
        endcase
        adding = $urandom_range(99) < add_pct;
        kind = $urandom_range(2);
        rq.position = 7'($urandom_range(127));
        if (adding) begin
            rq.action = (kind == 0) ? ACT_ADD_FRONT : (kind == 1) ? ACT_ADD_REAR : ACT_INS_POS;
            if (rq.action == ACT_INS_POS && $urandom_range(99) >= 10) begin
                rq.position = 7'($urandom_range(1, shadow_len + 1));
            end else if (rq.action == ACT_INS_POS) begin
                rq.position = ($urandom_range(1)) ? 7'd0 : 7'(shadow_len + 2);
            end
        end else begin
            rq.action = (kind == 0) ? ACT_DEL_FRONT : (kind == 1) ? ACT_DEL_REAR : ACT_DEL_POS;
            if (rq.action == ACT_DEL_POS && shadow_len > 0 && $urandom_range(99) >= 10) begin
                rq.position = 7'($urandom_range(1, shadow_len));
            end else if (rq.action == ACT_DEL_POS) begin
                rq.position = ($urandom_range(1)) ? 7'd0 : 7'(shadow_len + 1);
            end
        end
        return rq;
    endfunction

    // Offer one item, wait for the handshake, then record what it must produce.
    // Called at a rising edge; leaves at the edge that accepted the item.
    task automatic offer(input in_item_t rq, input bit has_exp, input out_item_t typed);
        out_item_t predicted;
        if (!quiet_stretch() && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 21);
        end
        s_valid <= 1'b1;
        s_item  <= rq;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(rq);
        pending_results.push_back(has_exp ? typed : predicted);
        items_in++;
    endtask

    // Sender: reset, directed table, then random segments with a shifting trend.
    initial begin : stimulus
        list_trend_t trend;
        int          seg_left;
        int          n;
        directed_rows = '{
            // empty list right after reset: every removal, bad insert position and undefined action fails
            drow(ACT_DEL_FRONT, 7'd0,   32'h0,         1, ST_UNDERFLOW, 32'h0, 7'd0),
            drow(ACT_DEL_REAR,  7'd0,   32'hFFFF_FFFF, 1, ST_UNDERFLOW, 32'h0, 7'd0),
            drow(ACT_DEL_POS,   7'd0,   32'h0,         1, ST_RANGE,     32'h0, 7'd0),
            drow(ACT_DEL_POS,   7'd1,   32'h0,         1, ST_RANGE,     32'h0, 7'd0),
            drow(ACT_INS_POS,   7'd0,   32'h1,         1, ST_RANGE,     32'h0, 7'd0),
            drow(ACT_INS_POS,   7'd2,   32'h1,         1, ST_RANGE,     32'h0, 7'd0),
            drow(ACT_UNDEF_6,   7'd1,   32'h0,         1, ST_RANGE,     32'h0, 7'd0),
            drow(ACT_UNDEF_7,   7'd127, 32'hFFFF_FFFF, 1, ST_RANGE,     32'h0, 7'd0),
            // build a short list through every add form
            drow(ACT_INS_POS,   7'd1,   32'h0,         1, ST_OK,        32'h0, 7'd1),
            drow(ACT_ADD_FRONT, 7'd0,   32'hFFFF_FFFF, 1, ST_OK,        32'h0, 7'd2),
            drow(ACT_ADD_REAR,  7'd127, 32'h8000_0000, 0, ST_OK,        32'h0, 7'd0),
            drow(ACT_INS_POS,   7'd4,   32'h1234_5678, 0, ST_OK,        32'h0, 7'd0),
            drow(ACT_INS_POS,   7'd2,   32'hA5A5_A5A5, 0, ST_OK,        32'h0, 7'd0),
            // positions past the end of a five-element list
            drow(ACT_DEL_POS,   7'd6,   32'h0,         1, ST_RANGE,     32'h0, 7'd5),
            drow(ACT_DEL_POS,   7'd127, 32'h0,         1, ST_RANGE,     32'h0, 7'd5),
            drow(ACT_INS_POS,   7'd7,   32'h7FFF_FFFF, 1, ST_RANGE,     32'h0, 7'd5),
            // take it apart again through every removal form
            drow(ACT_DEL_POS,   7'd3,   32'h0,         0, ST_OK,        32'h0, 7'd0),
            drow(ACT_DEL_FRONT, 7'd0,   32'h0,         0, ST_OK,        32'h0, 7'd0),
            drow(ACT_DEL_REAR,  7'd0,   32'h0,         0, ST_OK,        32'h0, 7'd0),
            drow(ACT_DEL_POS,   7'd1,   32'h0,         0, ST_OK,        32'h0, 7'd0),
            drow(ACT_DEL_POS,   7'd1,   32'h0,         0, ST_OK,        32'h0, 7'd0),
            drow(ACT_DEL_REAR,  7'd0,   32'h0,         1, ST_UNDERFLOW, 32'h0, 7'd0),
            drow(ACT_ADD_REAR,  7'd0,   32'h5A5A_5A5A, 1, ST_OK,        32'h0, 7'd1),
            drow(ACT_DEL_POS,   7'd1,   32'h0,         1, ST_OK,        32'h5A5A_5A5A, 7'd0)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].req, directed_rows[i].has_exp, directed_rows[i].exp);
        end

        // open with a long growth segment so the store runs full early
        trend = TREND_GROW;
        seg_left = 200;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                trend = list_trend_t'($urandom_range(2));
                seg_left = $urandom_range(80, 200);
            end
            seg_left--;
            offer(next_random(trend), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off to fill the block, quiet stretch.
    initial begin : result_sink
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && items_in >= 300) begin
                hold_done = 1'b1;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet_stretch() || $urandom_range(99) >= 21;
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: %p", m_item);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_item.status);
                    mismatch_count++;
                end
                if (m_item.removed_value !== want.removed_value) begin
                    $error("removed_value: expected %h, got %h",
                           want.removed_value, m_item.removed_value);
                    mismatch_count++;
                end
                if (m_item.item_count !== want.item_count) begin
                    $error("item_count: expected %0d, got %0d",
                           want.item_count, m_item.item_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
